// ----- hw/rtl/tccw_pkg.sv -----
package tccw_pkg;

	localparam int KIND_W = 3;
	localparam int CHAR_W = 8;
	localparam int COLOR_W = 8;
	localparam int CELL_W = COLOR_W + CHAR_W;

	localparam logic [KIND_W-1:0] KIND_CHAR    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SET     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_RESTORE = 3'd2;
	localparam logic [KIND_W-1:0] KIND_MOVE    = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CLRLINE = 3'd4;
	localparam logic [KIND_W-1:0] KIND_READ    = 3'd5;

	localparam logic [CHAR_W-1:0] DIR_UP    = 8'd0;
	localparam logic [CHAR_W-1:0] DIR_DOWN  = 8'd1;
	localparam logic [CHAR_W-1:0] DIR_LEFT  = 8'd2;
	localparam logic [CHAR_W-1:0] DIR_RIGHT = 8'd3;

	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

	localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;
	localparam logic [CELL_W-1:0] BLANK_CELL = {RESET_COLOR, CH_SPACE};

	// spaces written for one tab, minus one
	localparam logic [1:0] TAB_EXTRA = 2'd3;

endpackage

// ----- hw/rtl/tccw_ram.sv -----
module tccw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/text_console_cell_writer_top.sv -----
// Character-cell text console.
// Input words arrive on s_axis: tuser carries the kind (character, set color,
// restore color, move cursor, clear line, read cell), tdata the operands.
// Every input word produces exactly one output word on m_axis with the cursor,
// the active color and, for a read, the cell contents.
// Reset clears the cursor, sets both colors to RESET_COLOR, then sweeps the
// screen RAM to grey spaces, one cell per cycle, before s_axis_tready first
// rises. A scroll copies the screen through the single RAM port pair one cell
// per cycle.
// One word is worked on at a time; the next is accepted once the result is
// in the output register. A stalled receiver holds that register, and the
// block then waits with its next result finished.
module text_console_cell_writer_top
	import tccw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // value[7:0], cell_row[12:8], cell_col[19:13], zero
	input  logic [2:0]  s_axis_tuser,  // kind[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// cursor_row[4:0], cursor_col[11:5], cell_data[27:12], active_color[35:28], zero
	output logic [39:0] m_axis_tdata
);

	localparam int TOTAL = ROWS * COLUMNS;
	localparam int AW = $clog2(TOTAL);
	localparam int ROW_W = $clog2(ROWS);
	localparam int COL_W = $clog2(COLUMNS);
	localparam logic [ROW_W-1:0] Y_LAST = ROW_W'(ROWS - 1);
	localparam logic [COL_W-1:0] X_LAST = COL_W'(COLUMNS - 1);
	localparam logic [AW-1:0] A_LAST = AW'(TOTAL - 1);
	localparam logic [AW-1:0] A_COLS = AW'(COLUMNS);
	localparam logic [AW-1:0] A_LAST_ROW = AW'((ROWS - 1) * COLUMNS);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_CHAR   = 3'd2;
	localparam logic [2:0] ST_SCROLL = 3'd3;
	localparam logic [2:0] ST_DRAIN  = 3'd4;
	localparam logic [2:0] ST_FILL   = 3'd5;
	localparam logic [2:0] ST_READ   = 3'd6;
	localparam logic [2:0] ST_DONE   = 3'd7;

	logic [2:0]         state_q;
	logic [ROW_W-1:0]   cur_y_q;
	logic [COL_W-1:0]   cur_x_q;
	logic [COLOR_W-1:0] ink_q;
	logic [COLOR_W-1:0] saved_q;
	logic [CHAR_W-1:0]  char_q;
	logic [1:0]         cnt_q;
	logic               more_q;
	logic [AW-1:0]      addr_q;
	logic [COL_W-1:0]   col_q;
	logic               wr_valid_s1;
	logic [AW-1:0]      wr_addr_s1;
	logic [CELL_W-1:0]  data_q;
	logic               out_valid_q;
	logic [39:0]        out_data_q;

	logic [KIND_W-1:0]  in_kind;
	logic [CHAR_W-1:0]  in_value;
	logic [4:0]         in_row;
	logic [6:0]         in_col;
	logic               accept;
	logic               in_range;
	logic [AW-1:0]      in_addr;
	logic [AW-1:0]      cur_addr;
	logic [AW-1:0]      row_base;
	logic               out_free;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [CELL_W-1:0]  mem_wdata;
	logic               mem_re;
	logic [AW-1:0]      mem_raddr;
	logic [CELL_W-1:0]  mem_rdata;

	logic [31:0]        y_ext;
	logic [31:0]        x_ext;

	assign in_kind  = s_axis_tuser;
	assign in_value = s_axis_tdata[7:0];
	assign in_row   = s_axis_tdata[12:8];
	assign in_col   = s_axis_tdata[19:13];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	assign in_range = (32'(in_row) < 32'(ROWS)) && (32'(in_col) < 32'(COLUMNS));
	assign in_addr  = AW'(in_row) * A_COLS + AW'(in_col);
	assign row_base = AW'(cur_y_q) * A_COLS;
	assign cur_addr = row_base + AW'(cur_x_q);

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = {ink_q, CH_SPACE};
		mem_re = 1'b0;
		mem_raddr = addr_q;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wdata = BLANK_CELL;
			end
			ST_IDLE: begin
				mem_re = accept && (in_kind == KIND_READ) && in_range;
				mem_raddr = in_addr;
			end
			ST_CHAR: begin
				mem_we = 1'b1;
				mem_waddr = cur_addr;
				mem_wdata = {ink_q, char_q};
			end
			ST_SCROLL: begin
				mem_re = 1'b1;
				mem_we = wr_valid_s1;
				mem_waddr = wr_addr_s1;
				mem_wdata = mem_rdata;
			end
			ST_DRAIN: begin
				mem_we = wr_valid_s1;
				mem_waddr = wr_addr_s1;
				mem_wdata = mem_rdata;
			end
			ST_FILL: begin
				mem_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	tccw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(TOTAL)
	) u_screen (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cur_y_q <= '0;
			cur_x_q <= '0;
			ink_q <= RESET_COLOR;
			saved_q <= RESET_COLOR;
			cnt_q <= '0;
			more_q <= 1'b0;
			addr_q <= '0;
			col_q <= '0;
			wr_valid_s1 <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == A_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DONE;
						case (in_kind)
							KIND_CHAR: begin
								case (in_value)
									CH_NEWLINE: begin
										cur_x_q <= '0;
										more_q <= 1'b0;
										if (cur_y_q == Y_LAST) begin
											addr_q <= A_COLS;
											state_q <= ST_SCROLL;
										end else begin
											cur_y_q <= cur_y_q + 1'b1;
										end
									end
									CH_RETURN: begin
										cur_x_q <= '0;
									end
									CH_BACKSPACE: begin
										if (cur_x_q != '0) begin
											cur_x_q <= cur_x_q - 1'b1;
										end else if (cur_y_q != '0) begin
											cur_y_q <= cur_y_q - 1'b1;
											cur_x_q <= X_LAST;
										end
									end
									CH_TAB: begin
										char_q <= CH_SPACE;
										cnt_q <= TAB_EXTRA;
										state_q <= ST_CHAR;
									end
									default: begin
										char_q <= in_value;
										cnt_q <= '0;
										state_q <= ST_CHAR;
									end
								endcase
							end
							KIND_SET: begin
								saved_q <= ink_q;
								ink_q <= in_value;
							end
							KIND_RESTORE: begin
								saved_q <= ink_q;
								ink_q <= saved_q;
							end
							KIND_MOVE: begin
								case (in_value)
									DIR_UP: begin
										cur_y_q <= (cur_y_q == '0) ? Y_LAST : cur_y_q - 1'b1;
									end
									DIR_DOWN: begin
										cur_y_q <= (cur_y_q == Y_LAST) ? '0 : cur_y_q + 1'b1;
									end
									DIR_LEFT: begin
										cur_x_q <= (cur_x_q == '0) ? X_LAST : cur_x_q - 1'b1;
									end
									DIR_RIGHT: begin
										cur_x_q <= (cur_x_q == X_LAST) ? '0 : cur_x_q + 1'b1;
									end
									default: begin
									end
								endcase
							end
							KIND_CLRLINE: begin
								addr_q <= row_base;
								col_q <= '0;
								cur_x_q <= '0;
								more_q <= 1'b0;
								state_q <= ST_FILL;
							end
							KIND_READ: begin
								if (in_range) begin
									state_q <= ST_READ;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_CHAR: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - 1'b1;
					end
					if (cur_x_q == X_LAST) begin
						cur_x_q <= '0;
						if (cur_y_q == Y_LAST) begin
							// wrapped off the bottom: scroll, then finish the tab
							more_q <= (cnt_q != '0);
							addr_q <= A_COLS;
							state_q <= ST_SCROLL;
						end else begin
							cur_y_q <= cur_y_q + 1'b1;
							state_q <= (cnt_q != '0) ? ST_CHAR : ST_DONE;
						end
					end else begin
						cur_x_q <= cur_x_q + 1'b1;
						state_q <= (cnt_q != '0) ? ST_CHAR : ST_DONE;
					end
				end
				ST_SCROLL: begin
					// read cell at addr_q now, write it one row up next cycle
					addr_q <= addr_q + 1'b1;
					wr_addr_s1 <= addr_q - A_COLS;
					wr_valid_s1 <= 1'b1;
					if (addr_q == A_LAST) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					wr_valid_s1 <= 1'b0;
					addr_q <= A_LAST_ROW;
					col_q <= '0;
					state_q <= ST_FILL;
				end
				ST_FILL: begin
					addr_q <= addr_q + 1'b1;
					col_q <= col_q + 1'b1;
					if (col_q == X_LAST) begin
						more_q <= 1'b0;
						state_q <= more_q ? ST_CHAR : ST_DONE;
					end
				end
				ST_READ: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// read result; zero for every other kind and for an out-of-range read
	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= '0;
		end else if (state_q == ST_READ) begin
			data_q <= mem_rdata;
		end
	end

	assign y_ext = 32'(cur_y_q);
	assign x_ext = 32'(cur_x_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_data_q <= {4'b0, ink_q, data_q, x_ext[6:0], y_ext[4:0]};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

endmodule
